// File: hw/rtl/q5k_pkg.sv
package q5k_pkg;

    localparam int BLOCK_SIZE = 256;
    localparam int LANES    = 16;
    localparam int SB_W     = 3;
    localparam int SCALE_W  = 6;
    localparam int GSUM_W   = 12;
    localparam int PROD_W   = 13;
    localparam int SUM_W    = 17;
    localparam int DPROD_W  = 23;
    localparam int MPROD_W  = 18;
    localparam int DOT_W    = 27;
    localparam int MIN_W    = 22;
    localparam int IN_DATA_W  = 496;
    localparam int OUT_DATA_W = 56;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_BEAT   = 1'b1;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic                     valid;
        logic                     first;
        logic                     last;
        logic [SCALE_W-1:0]       scale;
        logic [SCALE_W-1:0]       min;
        logic signed [GSUM_W-1:0] gsum;
    } beat_ctrl_t;

endpackage

// File: hw/rtl/q5k_lane.sv
module q5k_lane
    import q5k_pkg::*;
(
    input  logic            clk,
    input  logic            advance,
    input  logic [SB_W-1:0] sb,
    input  logic [7:0]      nib_byte,
    input  logic [7:0]      hb_byte,
    input  logic [7:0]      act_byte,
    output prod_t           prod
);

    logic [3:0]         nib;
    logic               hbit;
    logic [4:0]         q;
    logic signed [13:0] full;
    prod_t              prod_reg;

    always_comb
    begin
        nib  = sb[0] ? nib_byte[7:4] : nib_byte[3:0];
        hbit = hb_byte[sb];
        q    = {hbit, nib};
        full = $signed({1'b0, q}) * $signed(act_byte);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= full[PROD_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

// File: hw/rtl/q5k_merge.sv
module q5k_merge
    import q5k_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  beat_ctrl_t              ctrl1,
    input  prod_t                   prod [LANES],
    output logic                    done,
    output logic signed [DOT_W-1:0] scaled_dot,
    output logic signed [MIN_W-1:0] min_dot
);

    logic signed [PROD_W:0]   lvl1 [8];
    logic signed [PROD_W+1:0] lvl2 [4];
    logic signed [PROD_W+2:0] lvl3 [2];
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [18:0]       mmul;
    logic signed [23:0]       dmul;

    beat_ctrl_t               ctrl2_reg;
    beat_ctrl_t               ctrl3_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [MPROD_W-1:0] mprod2_reg;
    logic signed [DPROD_W-1:0] dprod3_reg;
    logic signed [MPROD_W-1:0] mprod3_reg;
    logic signed [DOT_W-1:0]  dot_acc_reg;
    logic signed [DOT_W-1:0]  dot_acc_next;
    logic signed [MIN_W-1:0]  min_acc_reg;
    logic signed [MIN_W-1:0]  min_acc_next;

    // adder tree across lanes, with the min and scale products
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            lvl1[k] = (PROD_W+1)'(prod[2*k]) + (PROD_W+1)'(prod[2*k+1]);
        end
        for (int k = 0; k < 4; k++)
        begin
            lvl2[k] = (PROD_W+2)'(lvl1[2*k]) + (PROD_W+2)'(lvl1[2*k+1]);
        end
        for (int k = 0; k < 2; k++)
        begin
            lvl3[k] = (PROD_W+3)'(lvl2[2*k]) + (PROD_W+3)'(lvl2[2*k+1]);
        end
        sum_next = SUM_W'(lvl3[0]) + SUM_W'(lvl3[1]);
        mmul     = ctrl1.gsum * $signed({1'b0, ctrl1.min});
        dmul     = sum_reg * $signed({1'b0, ctrl2_reg.scale});
    end

    always_comb
    begin
        if (ctrl3_reg.first)
        begin
            dot_acc_next = DOT_W'(dprod3_reg);
            min_acc_next = MIN_W'(mprod3_reg);
        end
        else
        begin
            dot_acc_next = dot_acc_reg + DOT_W'(dprod3_reg);
            min_acc_next = min_acc_reg + MIN_W'(mprod3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else if (advance)
        begin
            ctrl2_reg <= ctrl1;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg    <= sum_next;
            mprod2_reg <= mmul[MPROD_W-1:0];
            dprod3_reg <= dmul[DPROD_W-1:0];
            mprod3_reg <= mprod2_reg;
            if (ctrl3_reg.valid)
            begin
                dot_acc_reg <= dot_acc_next;
                min_acc_reg <= min_acc_next;
            end
        end
    end

    assign done       = ctrl3_reg.valid && ctrl3_reg.last;
    assign scaled_dot = dot_acc_next;
    assign min_dot    = min_acc_next;

endmodule

// File: hw/rtl/q5k_q8k_superblock_dot.sv
// q5_k by q8_k super-block integer dot product
//
// input stream: one header word (tuser = 0) with the twelve packed scale bytes,
// then sixteen data words (tuser = 1), each with sixteen 5-bit weights, their
// int8 activations and the group sum of those activations
// output stream: one word per sixteen data words with the scaled dot sum and
// the min-weighted group sum
//
// sixteen lane multipliers take a data word per cycle unless stalled, a merge
// stage adds the lane products, applies the sub-block scale and accumulates
// throughput: one word per cycle on the input, headers included, unless stalled
// the last data word passes the lane, sum, scaled-product and output registers
//
// reset clears the scales to zero and the beat count; data words sent without
// a header use the scales last loaded
// when the receiver stalls with a result pending, the whole pipeline holds and
// tready drops until that result is taken
module q5k_q8k_superblock_dot
    import q5k_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // scale_bytes_low, scale_bytes_high, nibbles_first, nibbles_second,
    // highbits_first, highbits_second, acts_first, acts_second, act_group_sum
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // scaled_dot, min_dot
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int BEATS  = BLOCK_SIZE / LANES;
    localparam int BEAT_W = $clog2(BEATS);

    logic [63:0]             scale_lo;
    logic [31:0]             scale_hi;
    logic [8*LANES-1:0]      nib_all;
    logic [8*LANES-1:0]      hb_all;
    logic [8*LANES-1:0]      act_all;
    logic [7:0]              sbyte [12];

    logic                    stall;
    logic                    advance;
    logic                    accept;
    logic                    hdr_accept;
    logic                    beat_accept;
    logic [SB_W-1:0]         sb;
    logic                    beat_last;

    logic [BEAT_W-1:0]       beat_cnt_reg;
    logic [BEAT_W-1:0]       beat_cnt_next;
    logic [SCALE_W-1:0]      sub_scale_reg [8];
    logic [SCALE_W-1:0]      sub_scale_next [8];
    logic [SCALE_W-1:0]      sub_min_reg [8];
    logic [SCALE_W-1:0]      sub_min_next [8];
    beat_ctrl_t              ctrl1_reg;
    beat_ctrl_t              ctrl1_next;
    prod_t                   prod [LANES];

    logic                    done;
    logic signed [DOT_W-1:0] scaled_dot;
    logic signed [MIN_W-1:0] min_dot;
    logic                    out_valid_reg;
    logic [DOT_W-1:0]        out_dot_reg;
    logic [MIN_W-1:0]        out_min_reg;

    assign scale_lo = s_axis_tdata[63:0];
    assign scale_hi = s_axis_tdata[95:64];
    assign nib_all  = s_axis_tdata[223:96];
    assign hb_all   = s_axis_tdata[351:224];
    assign act_all  = s_axis_tdata[479:352];

    assign stall         = out_valid_reg && !m_axis_tready;
    assign advance       = !stall;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;
    assign hdr_accept    = accept && (s_axis_tuser == OP_HEADER);
    assign beat_accept   = accept && (s_axis_tuser == OP_BEAT);
    assign sb            = beat_cnt_reg[BEAT_W-1:BEAT_W-SB_W];
    assign beat_last     = (beat_cnt_reg == BEAT_W'(BEATS - 1));

    // scale unpacking
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            sbyte[j] = scale_lo[8*j +: 8];
        end
        for (int j = 0; j < 4; j++)
        begin
            sbyte[8+j] = scale_hi[8*j +: 8];
        end
        for (int j = 0; j < 8; j++)
        begin
            sub_scale_next[j] = sub_scale_reg[j];
            sub_min_next[j]   = sub_min_reg[j];
        end
        if (hdr_accept)
        begin
            for (int j = 0; j < 4; j++)
            begin
                sub_scale_next[j]   = sbyte[j][5:0];
                sub_min_next[j]     = sbyte[j+4][5:0];
                sub_scale_next[j+4] = {sbyte[j][7:6], sbyte[j+8][3:0]};
                sub_min_next[j+4]   = {sbyte[j+4][7:6], sbyte[j+8][7:4]};
            end
        end
    end

    always_comb
    begin
        beat_cnt_next = beat_cnt_reg;
        if (hdr_accept)
        begin
            beat_cnt_next = '0;
        end
        else if (beat_accept)
        begin
            beat_cnt_next = beat_cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        ctrl1_next.valid = beat_accept;
        ctrl1_next.first = (beat_cnt_reg == '0);
        ctrl1_next.last  = beat_last;
        ctrl1_next.scale = sub_scale_reg[sb];
        ctrl1_next.min   = sub_min_reg[sb];
        ctrl1_next.gsum  = $signed(s_axis_tdata[480 +: GSUM_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg  <= '0;
            ctrl1_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < 8; j++)
            begin
                sub_scale_reg[j] <= '0;
                sub_min_reg[j]   <= '0;
            end
        end
        else
        begin
            beat_cnt_reg <= beat_cnt_next;
            for (int j = 0; j < 8; j++)
            begin
                sub_scale_reg[j] <= sub_scale_next[j];
                sub_min_reg[j]   <= sub_min_next[j];
            end
            if (advance)
            begin
                ctrl1_reg     <= ctrl1_next;
                out_valid_reg <= done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && done)
        begin
            out_dot_reg <= scaled_dot;
            out_min_reg <= min_dot;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        q5k_lane u_lane
        (
            .clk      (clk),
            .advance  (advance),
            .sb       (sb),
            .nib_byte (nib_all[8*i +: 8]),
            .hb_byte  (hb_all[8*i +: 8]),
            .act_byte (act_all[8*i +: 8]),
            .prod     (prod[i])
        );
    end

    q5k_merge u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .ctrl1      (ctrl1_reg),
        .prod       (prod),
        .done       (done),
        .scaled_dot (scaled_dot),
        .min_dot    (min_dot)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W-DOT_W-MIN_W)'(0), out_min_reg, out_dot_reg};

    a_hdr_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_accept |=> (beat_cnt_reg == '0))
        else $error("header did not clear beat count");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(beat_cnt_reg))
        else $error("beat count moved without an accepted word");

    a_beat_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        beat_accept |=> ctrl1_reg.valid)
        else $error("accepted beat missing from pipeline");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done))
        else $error("result raised without a finished block");

endmodule

// File: verif/q5k_test_pkg.sv
package q5k_test_pkg;

    import q5k_pkg::*;

    // input word, lowest field last
    typedef struct packed {
        logic [IN_DATA_W-493:0]   fill;
        logic signed [GSUM_W-1:0] act_group_sum;
        logic [63:0]              acts_second;
        logic [63:0]              acts_first;
        logic [63:0]              highbits_second;
        logic [63:0]              highbits_first;
        logic [63:0]              nibbles_second;
        logic [63:0]              nibbles_first;
        logic [31:0]              scale_bytes_high;
        logic [63:0]              scale_bytes_low;
    } beat_word_t;

    typedef struct packed {
        logic [OUT_DATA_W-DOT_W-MIN_W-1:0] fill;
        logic signed [MIN_W-1:0]           min_dot;
        logic signed [DOT_W-1:0]           scaled_dot;
    } sums_t;

endpackage

// File: verif/q5k_q8k_superblock_dot_check.sv
module q5k_q8k_superblock_dot_check
    import q5k_pkg::*;
    import q5k_test_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SCALE_W-1:0] sub_scale [8];
    logic [SCALE_W-1:0] sub_min [8];
    logic [3:0]         beat_count;
    int                 dot_sum;
    int                 min_sum;
    sums_t              expected_sums [$];

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic note_failure(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic load_scales(input beat_word_t w);
        logic [7:0] b [12];
        for (int j = 0; j < 8; j++)
            b[j] = w.scale_bytes_low[8*j +: 8];
        for (int j = 0; j < 4; j++)
            b[8+j] = w.scale_bytes_high[8*j +: 8];
        for (int j = 0; j < 4; j++)
        begin
            sub_scale[j]   = b[j][5:0];
            sub_min[j]     = b[j+4][5:0];
            sub_scale[j+4] = {b[j][7:6], b[j+8][3:0]};
            sub_min[j+4]   = {b[j+4][7:6], b[j+8][7:4]};
        end
        beat_count = '0;
        dot_sum = 0;
        min_sum = 0;
    endtask

    task automatic accumulate_word(input beat_word_t w);
        logic [2:0] sb;
        logic [7:0] nb;
        logic [7:0] hb;
        logic [7:0] ab;
        logic [3:0] q;
        int         lane_sum;
        int         weight;
        int         act;
        int         gsum;
        sums_t      r;
        sb = beat_count[3:1];
        lane_sum = 0;
        for (int lane = 0; lane < LANES; lane++)
        begin
            nb = lane < 8 ? w.nibbles_first[8*lane +: 8] : w.nibbles_second[8*(lane-8) +: 8];
            hb = lane < 8 ? w.highbits_first[8*lane +: 8] : w.highbits_second[8*(lane-8) +: 8];
            ab = lane < 8 ? w.acts_first[8*lane +: 8] : w.acts_second[8*(lane-8) +: 8];
            q = sb[0] ? nb[7:4] : nb[3:0];
            weight = int'({hb[sb], q});
            act = int'($signed(ab));
            lane_sum += weight * act;
        end
        dot_sum += lane_sum * int'(sub_scale[sb]);
        gsum = int'(w.act_group_sum);
        min_sum += gsum * int'(sub_min[sb]);
        beat_count++;
        if (beat_count == 4'd0)
        begin
            r = '0;
            r.scaled_dot = dot_sum[DOT_W-1:0];
            r.min_dot = min_sum[MIN_W-1:0];
            expected_sums.push_back(r);
            dot_sum = 0;
            min_sum = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sums_t got;
        sums_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < 8; j++)
            begin
                sub_scale[j] = '0;
                sub_min[j] = '0;
            end
            beat_count = '0;
            dot_sum = 0;
            min_sum = 0;
            expected_sums.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_HEADER)
                    load_scales(s_axis_tdata);
                else
                    accumulate_word(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_sums.size() == 0)
                    note_failure($sformatf("unexpected result word %0d / %0d",
                                           got.scaled_dot, got.min_dot));
                else
                begin
                    want = expected_sums.pop_front();
                    if (got.scaled_dot !== want.scaled_dot)
                        note_failure($sformatf("scaled_dot got %0d expected %0d",
                                               got.scaled_dot, want.scaled_dot));
                    if (got.min_dot !== want.min_dot)
                        note_failure($sformatf("min_dot got %0d expected %0d",
                                               got.min_dot, want.min_dot));
                end
            end
        end
        pending = expected_sums.size();
    end

endmodule

// File: verif/q5k_q8k_superblock_dot_test.sv
module q5k_q8k_superblock_dot_test;
    import q5k_pkg::*;
    import q5k_test_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_COUNT     = 1500;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MOST_NEG, FILL_MOST_POS} fill_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int items_sent;
    int idle_cycles;
    bit gaps_on;
    bit hold_req;

    q5k_q8k_superblock_dot i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    q5k_q8k_superblock_dot_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    function automatic logic [63:0] lane_bytes(input fill_t mode);
        case (mode)
            FILL_ZERO:     return '0;
            FILL_ONES:     return '1;
            FILL_MOST_NEG: return {8{8'h80}};
            FILL_MOST_POS: return {8{8'h7f}};
            default:       return {$urandom, $urandom};
        endcase
    endfunction

    function automatic fill_t pick_fill();
        if ($urandom_range(0, 9) != 0)
            return FILL_RANDOM;
        return fill_t'($urandom_range(1, 4));
    endfunction

    function automatic beat_word_t make_header(input bit extreme);
        beat_word_t w;
        w = '0;
        w.scale_bytes_low  = extreme ? '1 : lane_bytes(pick_fill());
        w.scale_bytes_high = extreme ? '1 : 32'(lane_bytes(pick_fill()));
        // data fields are don't-care on a header
        w.nibbles_first   = lane_bytes(FILL_RANDOM);
        w.nibbles_second  = lane_bytes(FILL_RANDOM);
        w.highbits_first  = lane_bytes(FILL_RANDOM);
        w.highbits_second = lane_bytes(FILL_RANDOM);
        w.acts_first      = lane_bytes(FILL_RANDOM);
        w.acts_second     = lane_bytes(FILL_RANDOM);
        w.act_group_sum   = GSUM_W'($urandom);
        return w;
    endfunction

    function automatic beat_word_t make_beat(input bit extreme);
        beat_word_t w;
        fill_t      act_fill;
        int         total;
        w = '0;
        w.scale_bytes_low  = lane_bytes(FILL_RANDOM);
        w.scale_bytes_high = $urandom;
        if (extreme)
        begin
            act_fill = $urandom_range(0, 1) ? FILL_MOST_NEG : FILL_MOST_POS;
            w.nibbles_first   = '1;
            w.nibbles_second  = '1;
            w.highbits_first  = '1;
            w.highbits_second = '1;
            w.acts_first      = lane_bytes(act_fill);
            w.acts_second     = lane_bytes(act_fill);
        end
        else
        begin
            w.nibbles_first   = lane_bytes(pick_fill());
            w.nibbles_second  = lane_bytes(pick_fill());
            w.highbits_first  = lane_bytes(pick_fill());
            w.highbits_second = lane_bytes(pick_fill());
            w.acts_first      = lane_bytes(pick_fill());
            w.acts_second     = lane_bytes(pick_fill());
        end
        total = 0;
        for (int i = 0; i < 8; i++)
            total += int'($signed(w.acts_first[8*i +: 8])) + int'($signed(w.acts_second[8*i +: 8]));
        // group sum is normally consistent, sometimes deliberately off
        case (extreme ? 2 : $urandom_range(0, 9))
            0:       w.act_group_sum = GSUM_W'($urandom);
            1:       w.act_group_sum = $urandom_range(0, 1) ? 12'sh800 : 12'sh7ff;
            default: w.act_group_sum = GSUM_W'(total);
        endcase
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_word(input logic op, input beat_word_t w);
        while (gaps_on && $urandom_range(0, 99) < 20)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_block();
        int shape;
        int beats;
        bit extreme;
        shape = $urandom_range(0, 9);
        extreme = (shape == 9);
        if (shape != 8)
            send_word(OP_HEADER, make_header(extreme));
        beats = (shape == 7) ? $urandom_range(0, 15) : 16;
        repeat (beats)
            send_word(OP_BEAT, make_beat(extreme));
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
                hold_req = 1'b0;
            end
            else
                m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        beat_word_t w;
        int         block_num;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_HEADER;
        items_sent = 0;
        gaps_on = 1'b1;
        hold_req = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full block with no header: reset scales give zero sums
        for (int i = 0; i < 16; i++)
        begin
            w = '1;
            w.fill = '0;
            w.acts_first = i[0] ? {8{8'h7f}} : {8{8'h80}};
            w.acts_second = w.acts_first;
            w.act_group_sum = i[0] ? 12'sh7ff : 12'sh800;
            send_word(OP_BEAT, w);
        end
        // max scales, partial block, then a header mid-block drops it
        send_word(OP_HEADER, make_header(1'b1));
        repeat (3)
            send_word(OP_BEAT, make_beat(1'b1));
        send_word(OP_HEADER, '0);

        block_num = 0;
        while (items_sent < ITEM_COUNT)
        begin
            if (block_num == 12)
                hold_req = 1'b1;
            if (block_num == 30)
            begin
                s_axis_tvalid <= 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
            gaps_on = !(block_num >= 45 && block_num < 60);
            send_block();
            block_num++;
        end
        s_axis_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/q5k_pkg.sv
hw/rtl/q5k_lane.sv
hw/rtl/q5k_merge.sv
hw/rtl/q5k_q8k_superblock_dot.sv
verif/q5k_test_pkg.sv
verif/q5k_q8k_superblock_dot_check.sv
verif/q5k_q8k_superblock_dot_test.sv
